### design/lle_pkg.sv
package lle_pkg;

  // Image and arithmetic sizes
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int DATA_W      = 32;
  localparam int LVL_W       = DATA_W + 1;
  localparam int STEP_W      = 31;
  localparam int MODE_W      = 3;
  localparam int ROW_W       = 11;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int DIV_STAGES  = DATA_W;

  // Configuration port
  localparam int NUM_REGS = 4;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int PADDR_W  = IDX_W + 2;
  localparam int PDATA_W  = 32;

  // Result encoding and output queue
  localparam int MARK_W     = 8;
  localparam int OUTQ_DEPTH = 4;
  localparam int QA_W       = $clog2(OUTQ_DEPTH);
  localparam int QC_W       = $clog2(OUTQ_DEPTH + 1);
  localparam logic [MARK_W-1:0] MARK_ON  = MARK_W'(255);
  localparam logic [MARK_W-1:0] MARK_OFF = MARK_W'(0);

  typedef enum logic [IDX_W-1:0] {
    REG_OFFSET = 2'd0,
    REG_STEP   = 2'd1,
    REG_MODE   = 2'd2,
    REG_WIDTH  = 2'd3
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 3'd0,
    MODE_LINES  = 3'd1,
    MODE_SINGLE = 3'd2,
    MODE_LOWER  = 3'd3,
    MODE_UPPER  = 3'd4,
    MODE_BAND   = 3'd5
  } mode_t;

  // Register reset values
  localparam logic signed [DATA_W-1:0] OFFSET_RST = '0;
  localparam logic [STEP_W-1:0]        STEP_RST   = STEP_W'(65536);
  localparam mode_t                    MODE_RST   = MODE_LINES;
  localparam logic [ROW_W-1:0]         WIDTH_RST  = ROW_W'(1024);

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic signed [DATA_W-1:0] offset;
    logic [STEP_W-1:0]        step;
    mode_t                    mode;
    logic [CNT_W-1:0]         width;
  } cfg_t;

  // One sample with its position and line-buffer write-back
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ADDR_W-1:0]        col;
    logic                     first_row;
    logic                     last;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
  } pix_t;

  // One queued result; last adds the right-column zero with row_end
  typedef struct packed {
    logic marked;
    logic last;
  } res_t;

endpackage

### design/lle_ram.sv
module lle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lle_cfg.sv
module lle_cfg import lle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  logic signed [DATA_W-1:0] level_offset;
  logic [STEP_W-1:0]        level_step;
  mode_t                    extract_mode;
  logic [ROW_W-1:0]         row_width;
  reg_idx_t                 idx;
  logic                     wr;

  assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      level_offset <= OFFSET_RST;
      level_step   <= STEP_RST;
      extract_mode <= MODE_RST;
      row_width    <= WIDTH_RST;
    end else if (wr) begin
      case (idx)
        REG_OFFSET: level_offset <= signed'(pwdata[DATA_W-1:0]);
        REG_STEP:   level_step   <= pwdata[STEP_W-1:0];
        REG_MODE:   extract_mode <= mode_t'(pwdata[MODE_W-1:0]);
        REG_WIDTH:  row_width    <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      REG_OFFSET: prdata = PDATA_W'(unsigned'(level_offset));
      REG_STEP:   prdata = PDATA_W'(level_step);
      REG_MODE:   prdata = PDATA_W'(extract_mode);
      REG_WIDTH:  prdata = PDATA_W'(row_width);
      default:    prdata = '0;
    endcase
  end

  // Effective values: zero step acts as one, width clamped to [2, MAX_WIDTH]
  always_comb begin
    cfg.offset = level_offset;
    cfg.step   = (level_step == '0) ? STEP_W'(1) : level_step;
    cfg.mode   = extract_mode;
    if (int'(row_width) < 2) begin
      cfg.width = CNT_W'(2);
    end else if (int'(row_width) > MAX_WIDTH) begin
      cfg.width = CNT_W'(MAX_WIDTH);
    end else begin
      cfg.width = CNT_W'(row_width);
    end
  end

endmodule

### design/lle_div.sv
module lle_div import lle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  pix_t                    in_pix,
  input  cfg_t                    cfg,
  output logic                    out_valid,
  output pix_t                    out_pix,
  output logic signed [LVL_W-1:0] out_level
);

  // Offset subtraction stage
  logic                    a_valid;
  pix_t                    a_pix;
  logic signed [LVL_W-1:0] a_diff;
  logic [LVL_W-1:0]        a_mag;

  // Restoring divider: stage 0 holds the magnitude, stage k has k quotient bits
  logic [DIV_STAGES:0] st_valid;
  logic [DIV_STAGES:0] st_neg;
  pix_t                st_pix [DIV_STAGES+1];
  logic [DATA_W-1:0]   st_num [DIV_STAGES+1];
  logic [STEP_W-1:0]   st_rem [DIV_STAGES+1];

  logic [STEP_W:0]         trial   [DIV_STAGES];
  logic [STEP_W-1:0]       rem_new [DIV_STAGES];
  logic [DIV_STAGES-1:0]   take;
  logic [LVL_W-1:0]        q_ext;
  logic signed [LVL_W-1:0] level_calc;

  assign a_mag = a_diff[LVL_W-1] ? unsigned'(-a_diff) : unsigned'(a_diff);

  // One quotient bit per stage
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k]   = {st_rem[k], st_num[k][DATA_W-1]};
      take[k]    = trial[k] >= {1'b0, cfg.step};
      rem_new[k] = take[k] ? STEP_W'(trial[k] - {1'b0, cfg.step}) : trial[k][STEP_W-1:0];
    end
  end

  // Floor correction for negative dividends
  always_comb begin
    q_ext = {1'b0, st_num[DIV_STAGES]};
    if (!st_neg[DIV_STAGES]) begin
      level_calc = signed'(q_ext);
    end else if (st_rem[DIV_STAGES] != '0) begin
      level_calc = signed'(~q_ext);
    end else begin
      level_calc = signed'(-q_ext);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      st_valid  <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      st_valid  <= {st_valid[DIV_STAGES-1:0], a_valid};
      out_valid <= st_valid[DIV_STAGES];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix  <= in_pix;
      a_diff <= LVL_W'(in_pix.value) - LVL_W'(cfg.offset);

      st_pix[0] <= a_pix;
      st_neg[0] <= a_diff[LVL_W-1];
      st_num[0] <= a_mag[DATA_W-1:0];
      st_rem[0] <= '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_pix[k+1] <= st_pix[k];
        st_neg[k+1] <= st_neg[k];
        st_num[k+1] <= {st_num[k][DATA_W-2:0], take[k]};
        st_rem[k+1] <= rem_new[k];
      end

      out_pix   <= st_pix[DIV_STAGES];
      out_level <= level_calc;
    end
  end

endmodule

### design/lle_win.sv
module lle_win import lle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  pix_t                    in_pix,
  input  logic signed [LVL_W-1:0] in_level,
  input  cfg_t                    cfg,
  output logic                    push,
  output res_t                    push_res
);

  // Evaluation stage
  logic                    e_valid;
  pix_t                    e_pix;
  logic signed [LVL_W-1:0] e_level;
  logic                    fwd_hit;
  logic signed [DATA_W-1:0] fwd_smp;
  logic signed [LVL_W-1:0]  fwd_lvl;

  // Window registers: left pixel of this row, upper-left of the line
  logic signed [DATA_W-1:0] prev_smp;
  logic signed [LVL_W-1:0]  prev_lvl;
  logic signed [DATA_W-1:0] ul_smp;
  logic signed [LVL_W-1:0]  ul_lvl;
  logic signed [DATA_W-1:0] ur_smp;
  logic signed [LVL_W-1:0]  ur_lvl;

  logic [DATA_W-1:0] rd_smp;
  logic [LVL_W-1:0]  rd_lvl;
  logic              we;
  logic              re;
  logic              hit;

  logic ul_below, ul_at, ur_below, ur_at, pv_below, pv_at, cur_below, cur_at;
  logic [LVL_W-1:0] band_diff;
  logic             marked;

  function automatic logic crossing(logic a_below, logic a_at, logic b_below, logic b_at,
                                    logic differ);
    logic a_le;
    logic b_le;
    a_le = a_below | a_at;
    b_le = b_below | b_at;
    return ((a_le & !b_below) | (!a_below & b_le)) & differ;
  endfunction

  // Write back the left pixel while the next sample reads its column
  assign we  = adv & e_valid & e_pix.wr_en;
  assign re  = adv & in_valid;
  assign hit = e_valid & e_pix.wr_en & (e_pix.wr_addr == in_pix.col);

  lle_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_smp_ram (
    .clk   (clk),
    .we    (we),
    .waddr (e_pix.wr_addr),
    .wdata (unsigned'(prev_smp)),
    .re    (re),
    .raddr (in_pix.col),
    .rdata (rd_smp)
  );

  lle_ram #(.WIDTH(LVL_W), .DEPTH(MAX_WIDTH)) u_lvl_ram (
    .clk   (clk),
    .we    (we),
    .waddr (e_pix.wr_addr),
    .wdata (unsigned'(prev_lvl)),
    .re    (re),
    .raddr (in_pix.col),
    .rdata (rd_lvl)
  );

  // Upper-right entry, forwarded when written in the cycle it was read
  assign ur_smp = fwd_hit ? fwd_smp : signed'(rd_smp);
  assign ur_lvl = fwd_hit ? fwd_lvl : signed'(rd_lvl);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_pix   <= in_pix;
      e_level <= in_level;
      fwd_hit <= hit;
      fwd_smp <= prev_smp;
      fwd_lvl <= prev_lvl;
      if (e_valid) begin
        prev_smp <= e_pix.value;
        prev_lvl <= e_level;
        ul_smp   <= ur_smp;
        ul_lvl   <= ur_lvl;
      end
    end
  end

  // Mark decision on the 2x2 window
  always_comb begin
    ul_below  = ul_smp < cfg.offset;
    ul_at     = ul_smp == cfg.offset;
    ur_below  = ur_smp < cfg.offset;
    ur_at     = ur_smp == cfg.offset;
    pv_below  = prev_smp < cfg.offset;
    pv_at     = prev_smp == cfg.offset;
    cur_below = e_pix.value < cfg.offset;
    cur_at    = e_pix.value == cfg.offset;
    band_diff = unsigned'(LVL_W'(ul_smp) - LVL_W'(cfg.offset));
    case (cfg.mode)
      MODE_LINES:  marked = (ur_lvl != ul_lvl) | (prev_lvl != ul_lvl) | (e_level != ul_lvl);
      MODE_SINGLE: marked = crossing(ul_below, ul_at, ur_below, ur_at, ul_smp != ur_smp)
                          | crossing(ul_below, ul_at, pv_below, pv_at, ul_smp != prev_smp)
                          | crossing(ul_below, ul_at, cur_below, cur_at,
                                     ul_smp != e_pix.value);
      MODE_LOWER:  marked = ul_below;
      MODE_UPPER:  marked = !ul_below;
      MODE_BAND:   marked = !ul_below & (band_diff[DATA_W-1:0] < DATA_W'(cfg.step));
      default:     marked = 1'b0;
    endcase
  end

  // Results exist from column one on, below the first row
  assign push            = adv & e_valid & (e_pix.col != '0) & !e_pix.first_row;
  assign push_res.marked = marked;
  assign push_res.last   = e_pix.last;

endmodule

### design/lle_outq.sv
module lle_outq import lle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              push_res,
  output logic              adv,
  output logic              mark_valid,
  input  logic              mark_ready,
  output logic [MARK_W-1:0] mark,
  output logic              row_end
);

  res_t            q [OUTQ_DEPTH];
  logic [QA_W-1:0] head;
  logic [QA_W-1:0] tail;
  logic [QC_W-1:0] count;
  logic            phase;
  logic            xfer;
  logic            pop;

  // Room for one more item; the count is registered so ready does not see mark_ready
  assign adv        = count != QC_W'(OUTQ_DEPTH);
  assign mark_valid = count != '0;
  assign xfer       = mark_valid & mark_ready;
  assign pop        = xfer & (phase | !q[head].last);

  // phase 1 shows the right-column zero that closes a row
  assign mark    = (!phase && q[head].marked) ? MARK_ON : MARK_OFF;
  assign row_end = phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      phase <= 1'b0;
    end else begin
      if (push) begin
        tail <= (tail == QA_W'(OUTQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == QA_W'(OUTQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (xfer) begin
        phase <= !pop;
      end
      count <= QC_W'(count + QC_W'(push) - QC_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_res;
    end
  end

endmodule

### design/level_line_extractor.sv
// Path: the sample that completes a mark's 2x2 window passes the offset stage, the
//   33-stage restoring divider, the floor stage and the line read stage, then the queue.
// Throughput: one sample per cycle while the four-entry output queue has room; a full
//   queue stalls pixel_ready, and a row's last column adds an output for the right-column zero.
// Reset: synchronous rst empties the pipeline and queue, restarts the frame at column 0
//   and loads the register defaults; the line memories are not cleared.
module level_line_extractor import lle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  logic signed [DATA_W-1:0] pixel_value,
  input  logic                     frame_start,
  output logic                     mark_valid,
  input  logic                     mark_ready,
  output logic [MARK_W-1:0]        mark,
  output logic                     row_end
);

  cfg_t cfg;
  logic adv;
  logic accept;

  // Column tracking at the input
  logic [ADDR_W-1:0] col_count;
  logic              first_row_flag;
  logic [ADDR_W-1:0] prev_col;
  logic              prev_last;
  logic [ADDR_W-1:0] col;
  logic              first_row;
  logic [CNT_W-1:0]  col_plus;
  logic              last;
  pix_t              in_pix;

  logic                    l_valid;
  pix_t                    l_pix;
  logic signed [LVL_W-1:0] l_level;
  logic                    push;
  res_t                    push_res;

  assign pready      = 1'b1;
  assign pixel_ready = adv;
  assign accept      = pixel_valid & adv;

  lle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Position of the incoming sample; a count at or past the width starts a new row
  always_comb begin
    if (frame_start) begin
      col       = '0;
      first_row = 1'b1;
    end else if (CNT_W'(col_count) >= cfg.width) begin
      col       = '0;
      first_row = 1'b0;
    end else begin
      col       = col_count;
      first_row = first_row_flag;
    end
    col_plus = CNT_W'(col) + CNT_W'(1);
    last     = col_plus == cfg.width;

    in_pix.value     = DATA_W'(signed'(pixel_value[SAMPLE_BITS-1:0]));
    in_pix.col       = col;
    in_pix.first_row = first_row;
    in_pix.last      = last;
    // the previous sample goes to the line once its right neighbor arrives,
    // or at the next sample when it closed a row
    in_pix.wr_en     = (col != '0) | prev_last;
    in_pix.wr_addr   = prev_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count      <= '0;
      first_row_flag <= 1'b1;
      prev_col       <= '0;
      prev_last      <= 1'b0;
    end else if (accept) begin
      col_count      <= last ? '0 : col_plus[ADDR_W-1:0];
      first_row_flag <= last ? 1'b0 : first_row;
      prev_col       <= col;
      prev_last      <= last;
    end
  end

  lle_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pixel_valid),
    .in_pix    (in_pix),
    .cfg       (cfg),
    .out_valid (l_valid),
    .out_pix   (l_pix),
    .out_level (l_level)
  );

  lle_win u_win (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (l_valid),
    .in_pix   (l_pix),
    .in_level (l_level),
    .cfg      (cfg),
    .push     (push),
    .push_res (push_res)
  );

  lle_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_res   (push_res),
    .adv        (adv),
    .mark_valid (mark_valid),
    .mark_ready (mark_ready),
    .mark       (mark),
    .row_end    (row_end)
  );

endmodule
